### design/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg - shared types and constants of the MQTT PUBLISH deframer
// Result record, item kinds and the sizing constants used by the parser,
// the result queue and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mpd_pkg;

  // Packet type nibble of a PUBLISH fixed header
  localparam logic [3:0] PKT_PUBLISH = 4'h3;

  // Default body position limit for delivery
  localparam int MAX_BODY_DEF = 1024;

  // Delivery limit after reset: buffer capacity 1024 gives 1023 bytes
  localparam logic [9:0]  LIMIT_RESET = 10'd1023;
  localparam logic [10:0] CAP_CEIL    = 11'd1024;

  // Result queue depth; one item pushes at most two results
  localparam int QDEPTH = 4;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_SUMMARY = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e  kind;
    logic [7:0]  data;
    logic [3:0]  ptype;
    logic [9:0]  count;
    logic        bad;
  } result_t;

  // Results of one parsed byte, in delivery order
  typedef struct packed {
    logic    vld0;
    logic    vld1;
    result_t res0;
    result_t res1;
  } res_pair_t;

endpackage : mpd_pkg

`default_nettype wire

### design/mpd_parser.sv
// ----------------------------------------------------------------------------
// mpd_parser - MQTT 3.1.1 fixed header, length and PUBLISH body parser
// Consumes one byte per step and produces up to two ordered results.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_parser
  import mpd_pkg::*;
#(
  parameter int MaxBody = MAX_BODY_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [9:0] limit_i,
  output res_pair_t       res_o
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_BODY
  } phase_e;

  localparam logic [27:0] MaxBodyW = 28'(MaxBody);

  phase_e      phase_q, phase_d;
  logic [3:0]  type_q, type_d;
  logic [27:0] rlen_q, rlen_d;
  logic [1:0]  lidx_q, lidx_d;
  logic [27:0] pos_q, pos_d;
  logic [15:0] tlen_q, tlen_d;
  logic [9:0]  dcnt_q, dcnt_d;

  logic        is_pub;
  logic        deliver;
  logic        sum_vld;
  logic        sum_bad;
  logic        last_body;
  logic [27:0] rlen_acc;
  logic [27:0] topic_end;
  result_t     byte_res;
  result_t     sum_res;

  assign is_pub    = (type_q == PKT_PUBLISH);
  assign topic_end = 28'({1'b0, tlen_q} + 17'd2);
  assign last_body = ({1'b0, pos_q} + 29'd1) >= {1'b0, rlen_q};

  always_comb begin
    rlen_acc = rlen_q;
    unique case (lidx_q)
      2'd0: rlen_acc[6:0]   = byte_i[6:0];
      2'd1: rlen_acc[13:7]  = byte_i[6:0];
      2'd2: rlen_acc[20:14] = byte_i[6:0];
      2'd3: rlen_acc[27:21] = byte_i[6:0];
      default: rlen_acc = rlen_q;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    rlen_d  = rlen_q;
    lidx_d  = lidx_q;
    pos_d   = pos_q;
    tlen_d  = tlen_q;
    dcnt_d  = dcnt_q;
    deliver = 1'b0;
    sum_vld = 1'b0;
    sum_bad = 1'b0;

    if (step_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          type_d  = byte_i[7:4];
          rlen_d  = '0;
          lidx_d  = '0;
          phase_d = PH_LENGTH;
        end
        PH_LENGTH: begin
          rlen_d = rlen_acc;
          if (byte_i[7]) begin
            if (lidx_q == 2'd3) begin
              // overlong length: flag and resync on the next byte
              sum_vld = 1'b1;
              sum_bad = 1'b1;
              phase_d = PH_HEADER;
            end else begin
              lidx_d = lidx_q + 2'd1;
            end
          end else if (rlen_acc == '0) begin
            sum_vld = 1'b1;
            phase_d = PH_HEADER;
          end else begin
            pos_d   = '0;
            tlen_d  = '0;
            dcnt_d  = '0;
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          if (is_pub) begin
            if (pos_q == 28'd0) begin
              tlen_d = {byte_i, 8'h00};
            end else if (pos_q == 28'd1) begin
              tlen_d = {tlen_q[15:8], byte_i};
            end else if (pos_q >= topic_end && pos_q < MaxBodyW &&
                         dcnt_q < limit_i) begin
              deliver = 1'b1;
              dcnt_d  = dcnt_q + 10'd1;
            end
          end
          if (last_body) begin
            sum_vld = 1'b1;
            phase_d = PH_HEADER;
          end else begin
            pos_d = pos_q + 28'd1;
          end
        end
        default: phase_d = PH_HEADER;
      endcase
    end
  end

  always_comb begin
    byte_res       = '0;
    byte_res.kind  = KIND_BYTE;
    byte_res.data  = byte_i;
    byte_res.ptype = type_q;

    sum_res        = '0;
    sum_res.kind   = KIND_SUMMARY;
    sum_res.ptype  = type_q;
    sum_res.bad    = sum_bad;
    // count is still zero outside a PUBLISH body
    sum_res.count  = (phase_q == PH_BODY && is_pub) ? dcnt_d : 10'd0;

    res_o.vld0 = deliver | sum_vld;
    res_o.vld1 = deliver & sum_vld;
    res_o.res0 = deliver ? byte_res : sum_res;
    res_o.res1 = sum_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      type_q  <= '0;
      rlen_q  <= '0;
      lidx_q  <= '0;
      pos_q   <= '0;
      tlen_q  <= '0;
      dcnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      rlen_q  <= rlen_d;
      lidx_q  <= lidx_d;
      pos_q   <= pos_d;
      tlen_q  <= tlen_d;
      dcnt_q  <= dcnt_d;
    end
  end

  // A byte and a summary together: byte goes first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.vld1 |-> (res_o.res0.kind == KIND_BYTE && res_o.res1.kind == KIND_SUMMARY))
    else $error("mpd_parser: result pair out of order");

  // Body position stays below the remaining length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> pos_q < rlen_q)
    else $error("mpd_parser: body position ran past remaining length");

  // Delivered count never exceeds the limit it was checked against
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    deliver |-> dcnt_q < limit_i)
    else $error("mpd_parser: delivery beyond limit");

endmodule : mpd_parser

`default_nettype wire

### design/mpd_out_queue.sv
// ----------------------------------------------------------------------------
// mpd_out_queue - result queue of the deframer
// Takes up to two results per cycle, hands out one per output request.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_out_queue
  import mpd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire res_pair_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output result_t        head_o
);

  localparam int PtrW = $clog2(QDEPTH);
  localparam int CntW = $clog2(QDEPTH + 1);

  result_t           ent_q [QDEPTH];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;
  logic [1:0]        npush;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign head_o      = ent_q[rd_q];
  // room for a full pair without counting this cycle's pop
  assign room_o      = (cnt_q <= CntW'(QDEPTH - 2));
  assign npush       = {1'b0, push_i.vld0} + {1'b0, push_i.vld1};
  assign cnt_d       = cnt_q + CntW'(npush) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      ent_q[wr_q] <= push_i.res0;
    end
    if (push_i.vld1) begin
      ent_q[wr_q + PtrW'(1)] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(npush);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDEPTH))
    else $error("mpd_out_queue: overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.vld1 |-> push_i.vld0)
    else $error("mpd_out_queue: second result without first");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (npush != 2'd0) |-> $past(room_o, 1) || room_o)
    else $error("mpd_out_queue: push without room");

endmodule : mpd_out_queue

`default_nettype wire

### design/mqtt_publish_deframer_core.sv
// ----------------------------------------------------------------------------
// mqtt_publish_deframer_core - MQTT 3.1.1 PUBLISH payload deframer
// Parses a received byte stream into payload byte items and one summary
// item per packet.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------
//   in       | sink      | in_valid_i/in_ready_o  | rx_byte_i
//   out      | source    | out_valid_o/out_ready_i| item_kind_o, payload_byte_o,
//            |           |                        | packet_type_o,
//            |           |                        | bytes_delivered_o, malformed_o
//   cfg      | sink      | cfg_valid_i/cfg_ready_o| cfg_data_i (buffer capacity)
//
// One byte request is taken per cycle while in_ready_o is high. A byte is
// held in the input register, is parsed in a single pass and its results
// (zero, one or two) land in a four-entry result queue; the first result
// shows on the output once it is written into the queue.
// Sustained rate is one byte per cycle while the queue has room; a byte that
// closes a packet while also delivering a payload byte yields two results,
// which drain through the output port at one per cycle with out_ready_i high.
// The parser steps only while the queue holds two entries or fewer; with
// the output stalled the input register fills and in_ready_o drops.
// Reset clears the parser to "awaiting fixed header", empties the queue and
// sets the buffer capacity to 1024. The cfg port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mqtt_publish_deframer_core
  import mpd_pkg::*;
#(
  parameter int MaxBody = MAX_BODY_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             item_kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [3:0]       packet_type_o,
  output logic [9:0]       bytes_delivered_o,
  output logic             malformed_o,

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [10:0] cfg_data_i
);

  // Input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // Delivery limit derived from buffer capacity at write time
  logic [9:0] limit_q, limit_d;

  logic       room;
  logic       step;
  res_pair_t  pair;
  result_t    head;

  assign step        = in_vld_q && room;
  // take a new request when the held byte is empty or being parsed now
  assign in_ready_o  = !in_vld_q || step;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Capacity zero means no room; above 1024, cap at the 10-bit count range
  always_comb begin
    if (cfg_data_i == '0) begin
      limit_d = '0;
    end else if (cfg_data_i > CAP_CEIL) begin
      limit_d = LIMIT_RESET;
    end else begin
      limit_d = 10'(cfg_data_i - 11'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= limit_d;
    end
  end

  mpd_parser #(
    .MaxBody (MaxBody)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .limit_i (limit_q),
    .res_o   (pair)
  );

  mpd_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (pair),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign item_kind_o       = logic'(head.kind);
  assign payload_byte_o    = head.data;
  assign packet_type_o     = head.ptype;
  assign bytes_delivered_o = head.count;
  assign malformed_o       = head.bad;

  // No results without a parse step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair.vld0 |-> step)
    else $error("core: result without parse step");

  // A held byte with room is parsed in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && room) |=> (!in_vld_q || $past(in_valid_i && in_ready_o)))
    else $error("core: held byte not consumed");

  // A config write always updates the limit register to the derived value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> limit_q == $past(limit_d))
    else $error("core: limit update lost");

endmodule : mqtt_publish_deframer_core

`default_nettype wire

### bench/mqtt_publish_deframer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mqtt_publish_deframer_core_tb - self-checking bench for the PUBLISH deframer
// Feeds MQTT byte streams into the core and checks every result item against
// a parser written here. A short directed table opens the run, then random
// framed packets follow under several buffer capacities, with bursty input
// and a stalling output side.
// ----------------------------------------------------------------------------

module mqtt_publish_deframer_core_tb;
  import mpd_pkg::*;

  // Run limits and pacing
  localparam int CYC_LIMIT     = 400000; // watchdog, far above the slowest clean run
  localparam int SETTLE_CYC    = 8;      // covers bytes in flight that yield no result
  localparam int HOLD_CYC      = 250;    // long output stall that backs up the input
  localparam int RND_PER_PHASE = 106;    // minimum random byte requests per capacity setting
  localparam int NUM_PHASES    = 8;
  localparam int REPORT_MAX    = 40;     // stop printing mismatches after this many

  localparam result_t NO_RES = '0;

  typedef enum logic [1:0] {
    AWAIT_HDR,
    READ_LEN,
    IN_BODY
  } parse_ph_e;

  // One directed stimulus row; chk marks rows whose single result is typed in
  typedef struct packed {
    logic [7:0] rx;
    logic       chk;
    result_t    res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        item_kind_o;
  logic [7:0]  payload_byte_o;
  logic [3:0]  packet_type_o;
  logic [9:0]  bytes_delivered_o;
  logic        malformed_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i;

  mqtt_publish_deframer_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .item_kind_o      (item_kind_o),
    .payload_byte_o   (payload_byte_o),
    .packet_type_o    (packet_type_o),
    .bytes_delivered_o(bytes_delivered_o),
    .malformed_o      (malformed_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Directed table: header and length corner cases first. Typed results are
  // summaries that follow directly from the frame; the rest go through the
  // parser below.
  // --------------------------------------------------------------------------
  stim_row_t stim_tab [25] = '{
    // empty PUBLISH right after reset
    '{8'h30, 1'b0, NO_RES},
    '{8'h00, 1'b1, '{KIND_SUMMARY, 8'h00, 4'h3, 10'd0, 1'b0}},
    // overlong remaining length: fifth length byte never comes
    '{8'hF0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b1, '{KIND_SUMMARY, 8'h00, 4'hF, 10'd0, 1'b1}},
    // PUBLISH with one topic byte and two payload bytes at the byte extremes
    '{8'h3F, 1'b0, NO_RES},
    '{8'h05, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h01, 1'b0, NO_RES},
    '{8'h41, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    // short PUBLISH: topic length 0xFFFF, body ends after the length field
    '{8'h30, 1'b0, NO_RES},
    '{8'h02, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    // non-PUBLISH packet with a body: consumed, nothing delivered
    '{8'h00, 1'b0, NO_RES},
    '{8'h02, 1'b0, NO_RES},
    '{8'hAA, 1'b0, NO_RES},
    '{8'h55, 1'b0, NO_RES},
    // zero length in a padded two-byte encoding
    '{8'h20, 1'b0, NO_RES},
    '{8'h80, 1'b0, NO_RES},
    '{8'h00, 1'b1, '{KIND_SUMMARY, 8'h00, 4'h2, 10'd0, 1'b0}}
  };

  // Buffer capacity per phase; phase 0 runs on the reset value, -1 picks one
  int cap_plan [NUM_PHASES] = '{1024, 1, 0, 2047, 6, 1024, -1, 2};

  // Expected results, oldest first
  result_t pending [$];
  int      fail_cnt;

  // Sender side bookkeeping
  int      bytes_sent;
  int      burst_left;
  logic    gap_off;
  logic    row_chk;    // travels with the byte request on the input channel
  result_t row_res;
  logic    hold_req;   // toggled to start a long output stall

  // Parser shadow state and capacity register
  parse_ph_e   ps_phase;
  logic [3:0]  ps_type;
  logic [27:0] ps_rlen;
  logic [1:0]  ps_lidx;
  logic [27:0] ps_pos;
  logic [15:0] ps_topic;
  logic [9:0]  ps_count;
  logic [10:0] cap_reg;

  int unsigned cyc_cnt;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------

  // Payload bytes a packet may deliver under the current buffer capacity
  function automatic logic [9:0] deliver_cap(input logic [10:0] cap);
    logic [10:0] lim;
    lim = (cap == 11'd0) ? 11'd0 : cap - 11'd1;
    return (lim > 11'd1023) ? 10'd1023 : lim[9:0];
  endfunction

  task automatic add_result(input item_kind_e kind, input logic [7:0] data,
                            input logic [9:0] count, input logic bad, input logic keep);
    result_t r;
    r.kind  = kind;
    r.data  = data;
    r.ptype = ps_type;
    r.count = count;
    r.bad   = bad;
    if (keep) pending.push_back(r);
  endtask

  // Advance the shadow parser by one byte; queue its results if keep is set
  task automatic deframe_byte(input logic [7:0] b, input logic keep);
    logic [1:0]  idx;
    logic [31:0] pos;
    idx = ps_lidx;
    pos = {4'b0, ps_pos};
    case (ps_phase)
      READ_LEN: begin
        // seven bits per length byte, least significant group first
        ps_rlen = ps_rlen + (28'(b[6:0]) << (7 * idx));
        if (b[7]) begin
          if (idx == 2'd3) begin
            add_result(KIND_SUMMARY, 8'h00, 10'd0, 1'b1, keep);
            ps_phase = AWAIT_HDR;
          end else begin
            ps_lidx = idx + 2'd1;
          end
        end else if (ps_rlen == 28'd0) begin
          add_result(KIND_SUMMARY, 8'h00, 10'd0, 1'b0, keep);
          ps_phase = AWAIT_HDR;
        end else begin
          ps_pos   = '0;
          ps_topic = '0;
          ps_count = '0;
          ps_phase = IN_BODY;
        end
      end
      IN_BODY: begin
        if (ps_type == PKT_PUBLISH) begin
          if (pos == 32'd0) begin
            ps_topic = {b, 8'h00};
          end else if (pos == 32'd1) begin
            ps_topic[7:0] = b;
          end else if (pos >= 32'd2 + ps_topic && pos < MAX_BODY_DEF &&
                       ps_count < deliver_cap(cap_reg)) begin
            add_result(KIND_BYTE, b, 10'd0, 1'b0, keep);
            ps_count = ps_count + 10'd1;
          end
        end
        // the summary follows the byte result on the last body byte
        if (pos + 32'd1 >= {4'b0, ps_rlen}) begin
          add_result(KIND_SUMMARY, 8'h00, (ps_type == PKT_PUBLISH) ? ps_count : 10'd0,
                     1'b0, keep);
          ps_phase = AWAIT_HDR;
        end else begin
          ps_pos = ps_pos + 28'd1;
        end
      end
      default: begin
        ps_type  = b[7:4];
        ps_rlen  = '0;
        ps_lidx  = '0;
        ps_phase = READ_LEN;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      fail_cnt++;
      if (fail_cnt <= REPORT_MAX)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: track config and byte requests into the shadow parser, then
  // compare each accepted result with the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      ps_phase = AWAIT_HDR;
      ps_type  = '0;
      ps_rlen  = '0;
      ps_lidx  = '0;
      ps_pos   = '0;
      ps_topic = '0;
      ps_count = '0;
      cap_reg  = CAP_CEIL;
    end else begin
      if (cfg_valid_i && cfg_ready_o) cap_reg = cfg_data_i;
      if (in_valid_i && in_ready_o) begin
        // typed rows replace the parser's results but still advance its state
        deframe_byte(rx_byte_i, !row_chk);
        if (row_chk) pending.push_back(row_res);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("%0t ns: unexpected result, expected none, got kind %0h byte %0h",
                     $time, item_kind_o, payload_byte_o);
        end else begin
          want = pending.pop_front();
          check_field("item_kind", want.kind, item_kind_o);
          check_field("payload_byte", want.data, payload_byte_o);
          check_field("packet_type", want.ptype, packet_type_o);
          check_field("bytes_delivered", want.count, bytes_delivered_o);
          check_field("malformed", want.bad, malformed_o);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYC_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, pending.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall in a mode redrawn at random (always ready, random, a rotating
  // pattern or mostly low); hold off for a long stretch whenever the sender
  // toggles hold_req.
  initial begin
    logic       hold_ack;
    int         hold_left;
    int         mode;
    int         mode_left;
    logic [7:0] pat;
    hold_ack  = 1'b0;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    pat       = 8'hFF;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYC;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
        pat       = 8'($urandom);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: begin
            out_ready_i <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. Each starts and returns right after a rising edge.
  // --------------------------------------------------------------------------

  // Offer one byte request and hold it until taken; then either keep the
  // burst going or drop valid for a random gap.
  task automatic send_byte(input logic [7:0] b, input logic chk = 1'b0,
                           input result_t r = NO_RES);
    rx_byte_i  <= b;
    in_valid_i <= 1'b1;
    row_chk    <= chk;
    row_res    <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
    if (!gap_off) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Send one framed packet: header, remaining length (sometimes padded with
  // zero groups up to four bytes), then the body. PUBLISH bodies open with
  // the topic length, big-endian.
  task automatic emit_frame(input logic [7:0] hdr, input int unsigned rl,
                            input logic [15:0] tl);
    int unsigned nlen;
    int unsigned i;
    nlen = (rl < 128) ? 1 : (rl < 16384) ? 2 : 3;
    if ($urandom_range(0, 4) == 0) nlen = $urandom_range(nlen, 4);
    send_byte(hdr);
    for (i = 0; i < nlen; i++)
      send_byte({1'(i + 1 < nlen), 7'(rl >> (7 * i))});
    for (i = 0; i < rl; i++) begin
      if (hdr[7:4] == PKT_PUBLISH && i == 0) send_byte(tl[15:8]);
      else if (hdr[7:4] == PKT_PUBLISH && i == 1) send_byte(tl[7:0]);
      else send_byte(8'($urandom));
    end
  endtask

  // Mostly well-formed PUBLISH packets; the rest are other packet types,
  // short PUBLISH bodies, overlong lengths and empty packets.
  task automatic gen_packet();
    int unsigned sel;
    int unsigned tl;
    int unsigned rl;
    logic [3:0]  ptype;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      tl = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 4);
      emit_frame({PKT_PUBLISH, 4'($urandom)}, 2 + tl + $urandom_range(0, 24), 16'(tl));
    end else if (sel < 78) begin
      ptype = 4'($urandom);
      if (ptype == PKT_PUBLISH) ptype = 4'hC;
      emit_frame({ptype, 4'($urandom)}, $urandom_range(0, 12), 16'($urandom));
    end else if (sel < 90) begin
      // body ends inside the topic or right at its end
      tl = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 6);
      rl = $urandom_range(0, (tl > 8) ? 10 : 2 + tl);
      emit_frame({PKT_PUBLISH, 4'($urandom)}, rl, 16'(tl));
    end else if (sel < 96) begin
      send_byte(8'($urandom));
      repeat (4) send_byte({1'b1, 7'($urandom)});
    end else begin
      emit_frame(8'($urandom), 0, 16'd0);
    end
  endtask

  // Wait for every expected result, then let bytes without results drain
  task automatic settle();
    while (pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_cap(input logic [10:0] cap);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int ph;
    int cap;
    int i;
    int phase_end;
    fail_cnt   = 0;
    bytes_sent = 0;
    burst_left = 0;
    gap_off    = 1'b0;
    cyc_cnt    <= 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    rx_byte_i   <= 8'h00;
    row_chk     <= 1'b0;
    row_res     <= NO_RES;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    hold_req    <= 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        // walk the directed table on the reset capacity
        for (i = 0; i < 25; i++)
          send_byte(stim_tab[i].rx, stim_tab[i].chk, stim_tab[i].res);

        // hold the output off while one long PUBLISH streams in without gaps,
        // so the result queue fills and the input stalls
        hold_req <= ~hold_req;
        gap_off = 1'b1;
        emit_frame({PKT_PUBLISH, 4'h0}, 65, 16'd3);
        gap_off = 1'b0;
      end else begin
        // change capacity only with the core idle
        in_valid_i <= 1'b0;
        settle();
        cap = (cap_plan[ph] < 0) ? $urandom_range(2, 40) : cap_plan[ph];
        write_cap(11'(cap));
      end

      // one body past the position limit, with capacity above the count ceiling
      if (cap_plan[ph] == 2047) emit_frame({PKT_PUBLISH, 4'h1}, 1100, 16'd0);

      phase_end = bytes_sent + RND_PER_PHASE;
      while (bytes_sent < phase_end) gen_packet();
    end

    in_valid_i <= 1'b0;
    settle();
    if (fail_cnt == 0 && pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending.size() != 0)
        $display("%0t ns: %0d expected results never arrived", $time, pending.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
